[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker modules of this block.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define LKR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/lkr_pkg.sv]
// Shared types, constants and helper functions of the LRU-K frame replacer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package lkr_pkg;

    localparam int FRAMES_DEF = 64;
    localparam int FRAME_W    = 7;
    localparam int CNT_W      = 5;
    localparam int K_W        = 4;
    localparam logic [K_W-1:0] K_RESET = 4'd2;
    localparam int GROUP      = 8;

    localparam int S_DATA_W   = 8;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 16;
    localparam int TOTAL_W    = 7;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Register index of the history threshold.
    localparam logic REG_K = 1'b0;

    typedef enum logic [1:0] {
        K_ACCESS = 2'd0,
        K_SETEV  = 2'd1,
        K_REMOVE = 2'd2,
        K_EVICT  = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    typedef enum logic {
        L_HIST,
        L_CACHE
    } t_list;

    typedef struct packed {
        logic               vld;
        logic [FRAME_W-1:0] frm;
        t_list              tag;
        logic [CNT_W-1:0]   cnt;
        logic               evc;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic match;
        logic evc_hist;
        logic evc_cache;
    } t_cell_flags;

    // Lowest set bit of an eight-bit group: {found, index}.
    function automatic logic [3:0] first8(input logic [GROUP-1:0] v);
        logic [3:0] res;
        res = '0;
        for (int i = GROUP - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

endpackage

[hw/rtl/lkr_cell.sv]
// One cell of the replacer chain: holds one list entry and shifts from its upper neighbour.
// Depends on lkr_pkg.
`timescale 1ns / 1ps

module lkr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkr_pkg::t_cell_ctl          i_ctl,
    input  lkr_pkg::t_entry             i_new,
    input  lkr_pkg::t_entry             i_upper,
    input  logic [lkr_pkg::FRAME_W-1:0] i_frame,
    output lkr_pkg::t_entry             o_ent,
    output lkr_pkg::t_cell_flags        o_flags
);
    import lkr_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    always_comb begin
        if (i_ctl.load) begin
            n_ent = i_new;
        end else if (i_ctl.shift) begin
            n_ent = i_upper;
        end else begin
            n_ent = r_ent;
        end
    end

    // Only the valid bit is control state; the rest is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_ent             = r_ent;
    assign o_flags.match     = r_ent.vld && (r_ent.frm == i_frame);
    assign o_flags.evc_hist  = r_ent.vld && r_ent.evc && (r_ent.tag == L_HIST);
    assign o_flags.evc_cache = r_ent.vld && r_ent.evc && (r_ent.tag == L_CACHE);

endmodule

[hw/rtl/lru_k_frame_replacer_unit.sv]
// Top level of the LRU-K frame replacer: stream ports, APB register and the cell chain.
// Depends on lkr_pkg and lkr_cell.
`timescale 1ns / 1ps

// The replacer tracks frames 0..FRAMES and works on one item at a time: the item is
// accepted and every cell of the chain compares itself against the frame id, the
// results being condensed per group of eight cells into registers; in the apply state
// the groups are resolved to one position and the whole chain updates at once. A new
// item is taken in the cycle after that, so the block takes no new item until the last
// one has updated the chain, and its result is registered with that update. A result
// waiting in the output register does not block the next item; only the update of the
// following item waits for that register to be free. Each chain cell holds one tracked
// frame with its access count, its evictable mark and the list it belongs to. Cells
// are kept in insertion order: a frame leaves the chain by having every later cell
// shift down one place, and joins at the tail, so the history and cache lists keep
// their oldest-first order interleaved in the one chain. Evict picks the lowest
// evictable history cell, else the lowest evictable cache cell. The threshold k is
// written through the APB port at byte address 0 and should only be changed while the
// block is idle.
module lru_k_frame_replacer_unit #(
    parameter int FRAMES = lkr_pkg::FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input items.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [lkr_pkg::S_DATA_W-1:0] s_axis_tdata,  // [6:0] frame, [7] evictable_flag
    input  logic [lkr_pkg::S_USER_W-1:0] s_axis_tuser,  // [1:0] kind
    // Result items.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [0] done_res, [7:1] victim_frame, [8] range_error, [15:9] evictable_total
    output logic [lkr_pkg::M_DATA_W-1:0] m_axis_tdata,
    // Configuration.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lkr_pkg::APB_AW-1:0]   paddr,
    input  logic [lkr_pkg::APB_DW-1:0]   pwdata,
    output logic [lkr_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import lkr_pkg::*;

    // Frame ids are seven bits wide, so at most 128 frames can ever be tracked.
    localparam int MAX_IDS = 2 ** FRAME_W;
    localparam int CELLS   = (FRAMES + 1 < MAX_IDS) ? FRAMES + 1 : MAX_IDS;
    localparam int PW      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LW      = $clog2(CELLS + 1);
    localparam int NG      = (CELLS + GROUP - 1) / GROUP;
    localparam logic [10:0] LAST_ID = 11'(FRAMES);

    // Configuration register.
    logic [K_W-1:0] r_k;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_K);
    assign prdata = (paddr[APB_AW-1] == REG_K) ? APB_DW'(r_k) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_RESET;
        end else if (cfg_wr) begin
            r_k <= pwdata[K_W-1:0];
        end
    end

    // Control state.
    t_state         r_state;
    t_state         n_state;
    logic [LW-1:0]  r_len;
    logic [LW-1:0]  n_len;
    logic [LW-1:0]  r_evcnt;
    logic [LW-1:0]  n_evcnt;
    logic           r_out_vld;
    logic [M_DATA_W-1:0] r_out;
    logic           s_acc;
    logic           commit;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign commit = (r_state == ST_APPLY) && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Cell chain.
    t_entry      ent   [CELLS];
    t_cell_flags flags [CELLS];
    t_cell_ctl   ctl   [CELLS];
    t_entry      new_ent;

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        t_entry upper;
        if (j < CELLS - 1) begin : g_mid
            assign upper = ent[j+1];
        end else begin : g_end
            assign upper = '0;
        end
        lkr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[j]),
            .i_new   (new_ent),
            .i_upper (upper),
            .i_frame (s_axis_tdata[FRAME_W-1:0]),
            .o_ent   (ent[j]),
            .o_flags (flags[j])
        );
    end

    // Flag vectors padded to whole groups.
    logic [NG*GROUP-1:0] v_match;
    logic [NG*GROUP-1:0] v_eh;
    logic [NG*GROUP-1:0] v_ec;
    logic [$bits(t_entry)-1:0] hit_vec;

    always_comb begin
        v_match = '0;
        v_eh    = '0;
        v_ec    = '0;
        hit_vec = '0;
        for (int j = 0; j < CELLS; j++) begin
            v_match[j] = flags[j].match;
            v_eh[j]    = flags[j].evc_hist;
            v_ec[j]    = flags[j].evc_cache;
            if (flags[j].match) begin
                hit_vec = hit_vec | ent[j];
            end
        end
    end

    // Per-group first-hit encodings, registered when the item is accepted.
    logic [3:0] g_m [NG];
    logic [3:0] g_h [NG];
    logic [3:0] g_c [NG];
    logic [3:0] r_gm [NG];
    logic [3:0] r_gh [NG];
    logic [3:0] r_gc [NG];

    for (genvar g = 0; g < NG; g++) begin : g_grp
        assign g_m[g] = first8(v_match[g*GROUP +: GROUP]);
        assign g_h[g] = first8(v_eh[g*GROUP +: GROUP]);
        assign g_c[g] = first8(v_ec[g*GROUP +: GROUP]);
    end

    // Item payload held for the update cycle.
    t_kind              r_kind;
    logic [FRAME_W-1:0] r_frm;
    logic               r_flag;
    logic               r_rng;
    t_entry             r_hit;

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_frm  <= s_axis_tdata[FRAME_W-1:0];
            r_flag <= s_axis_tdata[FRAME_W];
            r_rng  <= (11'(s_axis_tdata[FRAME_W-1:0]) <= LAST_ID);
            r_hit  <= t_entry'(hit_vec);
            r_gm   <= g_m;
            r_gh   <= g_h;
            r_gc   <= g_c;
        end
    end

    // Resolve the groups to chain positions; the lowest group wins.
    logic          m_found;
    logic          eh_found;
    logic          ec_found;
    logic [PW-1:0] m_pos;
    logic [PW-1:0] eh_pos;
    logic [PW-1:0] ec_pos;
    logic [PW-1:0] ev_pos;
    logic [FRAME_W-1:0] vic_frm;

    always_comb begin
        m_found  = 1'b0;
        eh_found = 1'b0;
        ec_found = 1'b0;
        m_pos    = '0;
        eh_pos   = '0;
        ec_pos   = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_gm[g][3]) begin
                m_found = 1'b1;
                m_pos   = PW'(g * GROUP + int'(r_gm[g][2:0]));
            end
            if (r_gh[g][3]) begin
                eh_found = 1'b1;
                eh_pos   = PW'(g * GROUP + int'(r_gh[g][2:0]));
            end
            if (r_gc[g][3]) begin
                ec_found = 1'b1;
                ec_pos   = PW'(g * GROUP + int'(r_gc[g][2:0]));
            end
        end
        ev_pos  = eh_found ? eh_pos : ec_pos;
        vic_frm = '0;
        for (int j = 0; j < CELLS; j++) begin
            if (PW'(j) == ev_pos) begin
                vic_frm = vic_frm | ent[j].frm;
            end
        end
    end

    // Update decision for the held item.
    logic               del;
    logic [PW-1:0]      dp;
    logic               app;
    logic [LW-1:0]      wpos;
    logic               res_done;
    logic [FRAME_W-1:0] res_vic;
    logic               res_err;
    logic [CNT_W-1:0]   kp1;
    logic [CNT_W-1:0]   base_cnt;
    logic [CNT_W-1:0]   cnt_inc;
    t_list              inc_tag;

    always_comb begin
        del      = 1'b0;
        dp       = '0;
        app      = 1'b0;
        wpos     = '0;
        new_ent  = r_hit;
        n_len    = r_len;
        n_evcnt  = r_evcnt;
        res_done = 1'b0;
        res_vic  = '0;
        res_err  = 1'b0;
        kp1      = {1'b0, r_k} + 5'd1;
        base_cnt = m_found ? r_hit.cnt : '0;
        cnt_inc  = (base_cnt < kp1) ? base_cnt + 5'd1 : base_cnt;
        inc_tag  = (cnt_inc >= {1'b0, r_k}) ? L_CACHE : L_HIST;
        case (r_kind)
            K_ACCESS: begin
                if (!r_rng) begin
                    res_err = 1'b1;
                end else if (m_found) begin
                    // A frame staying in the history list keeps its place; any other
                    // access moves it to the tail of the list it now belongs to.
                    new_ent.cnt = cnt_inc;
                    new_ent.tag = inc_tag;
                    app = 1'b1;
                    if (r_hit.tag == L_HIST && inc_tag == L_HIST) begin
                        wpos = LW'(m_pos);
                    end else begin
                        del  = 1'b1;
                        dp   = m_pos;
                        wpos = LW'(r_len - 1'b1);
                    end
                end else begin
                    new_ent = '{vld: 1'b1, frm: r_frm, tag: inc_tag, cnt: cnt_inc, evc: 1'b0};
                    app   = 1'b1;
                    wpos  = r_len;
                    n_len = LW'(r_len + 1'b1);
                end
            end
            K_SETEV: begin
                if (!r_rng) begin
                    res_err = 1'b1;
                end else if (m_found) begin
                    new_ent.evc = r_flag;
                    app  = 1'b1;
                    wpos = LW'(m_pos);
                    if (!r_hit.evc && r_flag) begin
                        n_evcnt = LW'(r_evcnt + 1'b1);
                    end else if (r_hit.evc && !r_flag && r_evcnt != '0) begin
                        n_evcnt = LW'(r_evcnt - 1'b1);
                    end
                end
            end
            K_REMOVE: begin
                // An id out of range is silently ignored here.
                if (r_rng && m_found && r_hit.evc) begin
                    del   = 1'b1;
                    dp    = m_pos;
                    n_len = LW'(r_len - 1'b1);
                    if (r_evcnt != '0) begin
                        n_evcnt = LW'(r_evcnt - 1'b1);
                    end
                end
            end
            K_EVICT: begin
                if (eh_found || ec_found) begin
                    del      = 1'b1;
                    dp       = ev_pos;
                    res_done = 1'b1;
                    res_vic  = vic_frm;
                    n_len    = LW'(r_len - 1'b1);
                    if (r_evcnt != '0) begin
                        n_evcnt = LW'(r_evcnt - 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < CELLS; j++) begin
            ctl[j].shift = commit && del && (PW'(j) >= dp);
            ctl[j].load  = commit && app && (LW'(j) == wpos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_evcnt   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (commit) begin
                r_len     <= n_len;
                r_evcnt   <= n_evcnt;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= {TOTAL_W'(n_evcnt), res_err, res_vic, res_done};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

[hw/rtl/lkr_checker.sv]
// Port-level checker of the LRU-K frame replacer, bound to the top level.
// Depends on lkr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lkr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lkr_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import lkr_pkg::*;

    // The block is busy for the cycle after it takes an item.
    `LKR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A fresh result only appears once an item taken earlier has passed the apply state into the output register.
    `LKR_ASSERT_IMPLY(a_result_follows_item, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

    // A stalled result holds.
    `LKR_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind lru_k_frame_replacer_unit lkr_checker u_lkr_checker (.*);
